@@ hw/rtl/fap_pkg.sv @@
// ----------------------------------------------------------------------------
// fap_pkg
// Shared types, constants and helper functions for the network-node
// address parser.
// ----------------------------------------------------------------------------
package fap_pkg;

   localparam int unsigned NumWidth  = 15;
   localparam int unsigned PartWidth = 16;
   localparam int unsigned NumParts  = 4;
   localparam int unsigned IdxWidth  = 2;

   localparam logic [NumWidth-1:0]  NUM_MAX  = 15'h7fff;
   localparam logic [NumWidth-1:0]  NUM_MIN  = 15'h0000;
   localparam logic [PartWidth-1:0] WILD_VAL = 16'hffff;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_P  = 8'h70;
   localparam logic [7:0] CH_UP_P  = 8'h50;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_N  = 8'h6e;
   localparam logic [7:0] CH_UP_N  = 8'h4e;
   localparam logic [7:0] CH_LO_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;

   localparam logic [IdxWidth-1:0] IX_ZONE  = 2'd0;
   localparam logic [IdxWidth-1:0] IX_NET   = 2'd1;
   localparam logic [IdxWidth-1:0] IX_NODE  = 2'd2;
   localparam logic [IdxWidth-1:0] IX_POINT = 2'd3;

   typedef enum logic [3:0] {
      PH_FIRST = 4'b0001,
      PH_FIDO  = 4'b0010,
      PH_SEG   = 4'b0100,
      PH_SKIP  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      LD_NONE  = 3'd0,
      LD_SLASH = 3'd1,
      LD_DOT   = 3'd2,
      LD_P     = 3'd3,
      LD_F     = 3'd4,
      LD_N     = 3'd5,
      LD_Z     = 3'd6,
      LD_BAD   = 3'd7
   } prefix_type;

   typedef enum logic [1:0] {
      K_NONE  = 2'd0,
      K_NUM   = 2'd1,
      K_STAR  = 2'd2,
      K_OTHER = 2'd3
   } letter_type;

   typedef struct packed {
      prefix_type          prefix;
      letter_type          letter;
      logic [NumWidth-1:0] value;
      logic                ended;
   } segment_type;

   localparam segment_type SEG_EMPTY = '{
      prefix: LD_NONE, letter: K_NONE, value: NUM_MIN, ended: 1'b0
   };

   typedef struct packed {
      phase_type                           phase;
      logic [NumParts-1:0]                 seen;
      segment_type                         seg;
      logic                                err;
      logic                                form;
      logic [NumParts-1:0][PartWidth-1:0]  parts;
   } state_type;

   typedef struct packed {
      logic [NumParts-1:0][PartWidth-1:0] parts;
      logic                               form;
      logic                               bad;
   } result_type;

   typedef enum logic [1:0] {
      CSR_DEFAULT_ZONE = 2'd0,
      CSR_DEFAULT_NET  = 2'd1,
      CSR_DEFAULT_NODE = 2'd2
   } csr_index_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic segment_type append_char(input segment_type s, input logic [7:0] c);
      segment_type r;
      logic [NumWidth+3:0] acc;
      r   = s;
      acc = ({4'b0000, s.value} * 19'd10) + {11'd0, c - CH_ZERO};
      if (s.letter == K_NONE) begin
         if (is_digit(c)) begin
            r.letter = K_NUM;
            r.value  = {7'd0, c - CH_ZERO};
            r.ended  = 1'b0;
         end else begin
            r.letter = (c == CH_STAR) ? K_STAR : K_OTHER;
         end
      end else if (s.letter == K_NUM && !s.ended) begin
         if (is_digit(c)) begin
            r.value = (acc > {4'b0000, NUM_MAX}) ? NUM_MAX : acc[NumWidth-1:0];
         end else begin
            r.ended = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/fap_step.sv @@
// ----------------------------------------------------------------------------
// fap_step
// Next-state and result logic of the address parser for one byte.
// ----------------------------------------------------------------------------
module fap_step import fap_pkg::*; (
   input  state_type           cur,
   input  logic [7:0]          char_in,
   input  logic                wildcard_ok,
   input  logic [NumWidth-1:0] dflt_zone,
   input  logic [NumWidth-1:0] dflt_net,
   input  logic [NumWidth-1:0] dflt_node,
   output state_type           nxt,
   output result_type          result
);

   state_type           eff;
   state_type           upd;
   logic                numlike;
   logic                do_take;
   logic [IdxWidth-1:0] take_idx;
   logic                do_fail;
   logic                do_append;
   logic                do_prefix;
   prefix_type          new_prefix;
   logic                to_skip;
   logic                first_seg;

   always_comb begin
      eff = cur;
      first_seg = (char_in == CH_LO_P) || (char_in == CH_UP_P) ||
                  (char_in == CH_LO_F) || (char_in == CH_UP_F);
      if (cur.phase == PH_FIRST) begin
         eff.parts[IX_ZONE]  = {1'b0, dflt_zone};
         eff.parts[IX_NET]   = {1'b0, dflt_net};
         eff.parts[IX_NODE]  = {1'b0, dflt_node};
         eff.parts[IX_POINT] = {1'b0, NUM_MIN};
         eff.seen  = '0;
         eff.err   = 1'b0;
         eff.seg   = SEG_EMPTY;
         eff.form  = first_seg;
         eff.phase = first_seg ? PH_SEG : PH_FIDO;
      end
   end

   always_comb begin
      numlike    = (eff.seg.letter == K_NUM) || (eff.seg.letter == K_STAR);
      do_take    = 1'b0;
      take_idx   = IX_ZONE;
      do_fail    = 1'b0;
      do_append  = 1'b0;
      do_prefix  = 1'b0;
      new_prefix = LD_NONE;
      to_skip    = 1'b0;
      unique case (eff.phase)
         PH_FIDO: begin
            if (char_in == CH_COLON) begin
               if (eff.seg.prefix == LD_NONE && numlike && !eff.seen[IX_ZONE]) begin
                  do_take = 1'b1;
                  take_idx = IX_ZONE;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (char_in == CH_SLASH) begin
               if (eff.seg.prefix == LD_NONE) begin
                  if (eff.seg.letter == K_NONE) begin
                     do_prefix = 1'b1;
                     new_prefix = LD_SLASH;
                  end else if (numlike && !eff.seen[IX_NET]) begin
                     do_take = 1'b1;
                     take_idx = IX_NET;
                  end else begin
                     do_fail = 1'b1;
                  end
               end else if (eff.seg.prefix == LD_SLASH) begin
                  do_append = 1'b1;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (char_in == CH_DOT) begin
               if (eff.seg.prefix == LD_DOT) begin
                  do_append = 1'b1;
               end else if (numlike && !eff.seen[IX_NODE]) begin
                  do_take = 1'b1;
                  take_idx = IX_NODE;
               end else if (eff.seg.letter == K_NONE) begin
                  do_prefix = 1'b1;
                  new_prefix = LD_DOT;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (char_in == CH_AT || char_in == CH_NUL) begin
               to_skip = 1'b1;
               if ((eff.seen[IX_ZONE] && !eff.seen[IX_NET]) || !numlike) begin
                  do_fail = 1'b1;
               end else if (eff.seg.prefix == LD_SLASH) begin
                  do_fail = eff.seen[IX_NODE];
                  do_take = !eff.seen[IX_NODE];
                  take_idx = IX_NODE;
               end else if (eff.seg.prefix == LD_DOT) begin
                  do_fail = eff.seen[IX_POINT];
                  do_take = !eff.seen[IX_POINT];
                  take_idx = IX_POINT;
               end else if (!eff.seen[IX_NODE]) begin
                  do_take = 1'b1;
                  take_idx = IX_NODE;
               end else if (!eff.seen[IX_POINT]) begin
                  do_take = 1'b1;
                  take_idx = IX_POINT;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (is_digit(char_in) || (char_in == CH_STAR && wildcard_ok)) begin
               do_append = 1'b1;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_SEG: begin
            if (char_in == CH_DOT || char_in == CH_NUL) begin
               unique case (eff.seg.prefix)
                  LD_P: begin
                     do_take = !eff.seen[IX_POINT];
                     take_idx = IX_POINT;
                  end
                  LD_F: begin
                     do_take = !eff.seen[IX_ZONE] && !eff.seen[IX_NET] &&
                               !eff.seen[IX_NODE];
                     take_idx = IX_NODE;
                  end
                  LD_N: begin
                     do_take = eff.seen[IX_NODE] && !eff.seen[IX_ZONE] &&
                               !eff.seen[IX_NET];
                     take_idx = IX_NET;
                  end
                  LD_Z: begin
                     do_take = eff.seen[IX_NODE] && eff.seen[IX_NET] &&
                               !eff.seen[IX_ZONE];
                     take_idx = IX_ZONE;
                     to_skip = 1'b1;
                  end
                  default: begin
                     do_take = 1'b0;
                  end
               endcase
               do_take = do_take && (eff.seg.letter == K_NUM);
               do_fail = !do_take;
            end else if (eff.seg.prefix == LD_NONE) begin
               do_prefix = 1'b1;
               if (char_in == CH_LO_P || char_in == CH_UP_P) begin
                  new_prefix = LD_P;
               end else if (char_in == CH_LO_F || char_in == CH_UP_F) begin
                  new_prefix = LD_F;
               end else if (char_in == CH_LO_N || char_in == CH_UP_N) begin
                  new_prefix = LD_N;
               end else if (char_in == CH_LO_Z || char_in == CH_UP_Z) begin
                  new_prefix = LD_Z;
               end else begin
                  new_prefix = LD_BAD;
               end
            end else begin
               do_append = 1'b1;
            end
         end
         default: begin
            do_take = 1'b0;
         end
      endcase
   end

   always_comb begin
      upd = eff;
      if (do_append) begin
         upd.seg = append_char(eff.seg, char_in);
      end
      if (do_prefix) begin
         upd.seg.prefix = new_prefix;
      end
      if (do_take) begin
         upd.parts[take_idx] = (eff.seg.letter == K_STAR) ? WILD_VAL :
                               {1'b0, eff.seg.value};
         upd.seen[take_idx] = 1'b1;
         upd.seg = SEG_EMPTY;
      end
      if (to_skip && !do_fail && do_take) begin
         upd.phase = PH_SKIP;
      end
      if (do_fail) begin
         upd.err = 1'b1;
         upd.phase = PH_SKIP;
      end
      nxt = upd;
      if (char_in == CH_NUL) begin
         nxt.phase = PH_FIRST;
      end
      result.parts = upd.err ? '0 : upd.parts;
      result.form  = upd.form;
      result.bad   = upd.err;
   end

endmodule

@@ hw/rtl/fido_address_parser.sv @@
// ----------------------------------------------------------------------------
// fido_address_parser
// Parses a network-node address string, one byte per transfer, into zone,
// net, node and point.
//
// The request channel carries one byte of the string per transfer, with
// the wildcard permission; a zero byte ends the string. Exactly one
// response transfer follows each zero byte and carries the four parts,
// the segment form flag and the bad flag. Other bytes give no response.
// The csr port sets the default zone, net and node, which are applied at
// the first byte of each string; write it only while the block is idle.
// A byte is held in an input register, then the parser state and the
// response register are updated from it in a single pass, and the
// response transfers from that register. One byte is taken in every
// cycle while the request channel does not stall.
// When the receiver stalls, the response register holds, and the request
// channel stalls only when a second zero byte reaches the input register
// behind a held response. Reset clears the defaults to zero and the
// parser waits for the first byte of a string.
// ----------------------------------------------------------------------------
module fido_address_parser import fap_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_char_in,
   input  logic                        req_wildcard_ok,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [PartWidth-1:0] rsp_zone_out,
   output logic signed [PartWidth-1:0] rsp_net_out,
   output logic signed [PartWidth-1:0] rsp_node_out,
   output logic signed [PartWidth-1:0] rsp_point_out,
   output logic                        rsp_segment_form,
   output logic                        rsp_bad,
   input  logic                        csr_write,
   input  logic [IdxWidth-1:0]         csr_index,
   input  logic [NumWidth-1:0]         csr_wdata
);

   logic [NumWidth-1:0] def_zone_ff;
   logic [NumWidth-1:0] def_net_ff;
   logic [NumWidth-1:0] def_node_ff;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_char_ff;
   logic                in_wild_ff;
   state_type           state_ff;
   state_type           state_in;
   result_type          result;
   result_type          rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                in_end;
   logic                advance;
   logic                req_take;
   logic                rsp_load;

   assign in_end    = (in_char_ff == CH_NUL);
   assign advance   = in_valid_ff && (!in_end || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = advance && in_end;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   fap_step u_step (
      .cur          (state_ff),
      .char_in      (in_char_ff),
      .wildcard_ok  (in_wild_ff),
      .dflt_zone    (def_zone_ff),
      .dflt_net     (def_net_ff),
      .dflt_node    (def_node_ff),
      .nxt          (state_in),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         def_zone_ff <= NUM_MIN;
         def_net_ff  <= NUM_MIN;
         def_node_ff <= NUM_MIN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEFAULT_ZONE: def_zone_ff <= csr_wdata;
            CSR_DEFAULT_NET:  def_net_ff  <= csr_wdata;
            CSR_DEFAULT_NODE: def_node_ff <= csr_wdata;
            default:          def_zone_ff <= def_zone_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{
            phase: PH_FIRST, seen: '0, seg: SEG_EMPTY, err: 1'b0, form: 1'b0, parts: '0
         };
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
         in_wild_ff <= req_wildcard_ok;
      end
      if (rsp_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_zone_out     = rsp_ff.parts[IX_ZONE];
   assign rsp_net_out      = rsp_ff.parts[IX_NET];
   assign rsp_node_out     = rsp_ff.parts[IX_NODE];
   assign rsp_point_out    = rsp_ff.parts[IX_POINT];
   assign rsp_segment_form = rsp_ff.form;
   assign rsp_bad          = rsp_ff.bad;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad |-> rsp_zone_out == '0 && rsp_net_out == '0 &&
                               rsp_node_out == '0 && rsp_point_out == '0)
      else $error("bad response carries nonzero parts");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_form && !rsp_bad |->
         !rsp_zone_out[PartWidth-1] && !rsp_net_out[PartWidth-1] &&
         !rsp_node_out[PartWidth-1] && !rsp_point_out[PartWidth-1])
      else $error("segment form response holds a wildcard");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_end && rsp_valid_ff && rsp_stall |=> in_valid_ff && in_end)
      else $error("end byte lost behind a stalled response");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the network-node address parser. Address strings
// are fed one byte per request transfer, and a scoreboard parses the same
// bytes to predict the response that each zero byte must bring. Strings
// are mostly well-formed in both the colon form and the segment form,
// with random content, and the rest are mutated strings and raw noise.
// The default registers are changed between phases while the block is
// idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import fap_pkg::*;

   localparam int HoldCycles = 400;
   localparam int SettleCycles = 4;
   localparam int PhaseBytes = 320;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   class address_scoreboard;
      logic [NumWidth-1:0]  dflt_zone = NUM_MIN;
      logic [NumWidth-1:0]  dflt_net = NUM_MIN;
      logic [NumWidth-1:0]  dflt_node = NUM_MIN;
      phase_type            parse_phase = PH_FIRST;
      logic [NumParts-1:0]  seen_parts;
      prefix_type           seg_prefix;
      letter_type           seg_letter;
      logic [NumWidth-1:0]  seg_value;
      logic                 digits_done;
      logic                 malformed;
      logic                 seg_form = 1'b0;
      logic [PartWidth-1:0] part_value [NumParts];
      result_type           expected_addresses [$];
      int                   fail_count = 0;
      int                   string_count = 0;
      int                   seg_count = 0;
      int                   bad_count = 0;

      function new();
         open_string();
      endfunction

      function void set_default(csr_index_type idx, logic [NumWidth-1:0] v);
         case (idx)
            CSR_DEFAULT_ZONE: dflt_zone = v;
            CSR_DEFAULT_NET:  dflt_net = v;
            CSR_DEFAULT_NODE: dflt_node = v;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_addresses.size();
      endfunction

      function void clear_segment();
         seg_prefix = LD_NONE;
         seg_letter = K_NONE;
         seg_value = NUM_MIN;
         digits_done = 1'b0;
      endfunction

      function void open_string();
         part_value[IX_ZONE] = {1'b0, dflt_zone};
         part_value[IX_NET] = {1'b0, dflt_net};
         part_value[IX_NODE] = {1'b0, dflt_node};
         part_value[IX_POINT] = {1'b0, NUM_MIN};
         seen_parts = '0;
         malformed = 1'b0;
         clear_segment();
      endfunction

      function void mark_bad();
         malformed = 1'b1;
         parse_phase = PH_SKIP;
      endfunction

      function bit is_num(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit numeric();
         return seg_letter == K_NUM || seg_letter == K_STAR;
      endfunction

      // Only the leading digits of a part count; the value saturates.
      function void add_char(logic [7:0] c);
         int unsigned acc;
         if (seg_letter == K_NONE) begin
            if (is_num(c)) begin
               seg_letter = K_NUM;
               seg_value = NumWidth'(c - CH_ZERO);
               digits_done = 1'b0;
            end else begin
               seg_letter = (c == CH_STAR) ? K_STAR : K_OTHER;
            end
         end else if (seg_letter == K_NUM && !digits_done) begin
            if (is_num(c)) begin
               acc = seg_value;
               acc = acc * 10 + (c - CH_ZERO);
               seg_value = (acc > NUM_MAX) ? NUM_MAX : acc[NumWidth-1:0];
            end else begin
               digits_done = 1'b1;
            end
         end
      endfunction

      function void store_part(logic [IdxWidth-1:0] ix);
         part_value[ix] = (seg_letter == K_STAR) ? WILD_VAL : {1'b0, seg_value};
         seen_parts[ix] = 1'b1;
         clear_segment();
      endfunction

      function void close_colon_form();
         if (seen_parts[IX_ZONE] && !seen_parts[IX_NET]) begin
            mark_bad();
            return;
         end
         if (!numeric()) begin
            mark_bad();
            return;
         end
         if (seg_prefix == LD_SLASH) begin
            if (seen_parts[IX_NODE]) begin
               mark_bad();
               return;
            end
            store_part(IX_NODE);
         end else if (seg_prefix == LD_DOT) begin
            if (seen_parts[IX_POINT]) begin
               mark_bad();
               return;
            end
            store_part(IX_POINT);
         end else if (!seen_parts[IX_NODE]) begin
            store_part(IX_NODE);
         end else if (!seen_parts[IX_POINT]) begin
            store_part(IX_POINT);
         end else begin
            mark_bad();
            return;
         end
         parse_phase = PH_SKIP;
      endfunction

      function void colon_byte(logic [7:0] c, logic wild);
         case (c)
            CH_COLON: begin
               if (seg_prefix == LD_NONE && numeric() && !seen_parts[IX_ZONE])
                  store_part(IX_ZONE);
               else
                  mark_bad();
            end
            CH_SLASH: begin
               if (seg_prefix == LD_NONE) begin
                  if (seg_letter == K_NONE) seg_prefix = LD_SLASH;
                  else if (numeric() && !seen_parts[IX_NET]) store_part(IX_NET);
                  else mark_bad();
               end else if (seg_prefix == LD_SLASH) begin
                  add_char(c);
               end else begin
                  mark_bad();
               end
            end
            CH_DOT: begin
               if (seg_prefix == LD_DOT) add_char(c);
               else if (numeric() && !seen_parts[IX_NODE]) store_part(IX_NODE);
               else if (seg_letter == K_NONE) seg_prefix = LD_DOT;
               else mark_bad();
            end
            CH_AT, CH_NUL: close_colon_form();
            default: begin
               if (is_num(c) || (c == CH_STAR && wild)) add_char(c);
               else mark_bad();
            end
         endcase
      endfunction

      function void segment_byte(logic [7:0] c);
         bit ok;
         if (c == CH_DOT || c == CH_NUL) begin
            ok = seg_letter == K_NUM;
            case (seg_prefix)
               LD_P: begin
                  ok = ok && !seen_parts[IX_POINT];
                  if (ok) store_part(IX_POINT);
               end
               LD_F: begin
                  ok = ok && !seen_parts[IX_ZONE] && !seen_parts[IX_NET]
                     && !seen_parts[IX_NODE];
                  if (ok) store_part(IX_NODE);
               end
               LD_N: begin
                  ok = ok && seen_parts[IX_NODE] && !seen_parts[IX_ZONE]
                     && !seen_parts[IX_NET];
                  if (ok) store_part(IX_NET);
               end
               LD_Z: begin
                  ok = ok && seen_parts[IX_NODE] && seen_parts[IX_NET]
                     && !seen_parts[IX_ZONE];
                  if (ok) begin
                     store_part(IX_ZONE);
                     parse_phase = PH_SKIP;
                  end
               end
               default: ok = 1'b0;
            endcase
            if (!ok) mark_bad();
            return;
         end
         if (seg_prefix == LD_NONE) begin
            if (c == CH_LO_P || c == CH_UP_P) seg_prefix = LD_P;
            else if (c == CH_LO_F || c == CH_UP_F) seg_prefix = LD_F;
            else if (c == CH_LO_N || c == CH_UP_N) seg_prefix = LD_N;
            else if (c == CH_LO_Z || c == CH_UP_Z) seg_prefix = LD_Z;
            else seg_prefix = LD_BAD;
         end else begin
            add_char(c);
         end
      endfunction

      // Called for every accepted request transfer.
      function void note_byte(logic [7:0] c, logic wild);
         result_type want;
         if (parse_phase == PH_FIRST) begin
            open_string();
            seg_form = (c == CH_LO_P || c == CH_UP_P || c == CH_LO_F || c == CH_UP_F);
            parse_phase = seg_form ? PH_SEG : PH_FIDO;
         end
         if (parse_phase == PH_FIDO) colon_byte(c, wild);
         else if (parse_phase == PH_SEG) segment_byte(c);
         if (c != CH_NUL) return;
         for (int i = 0; i < NumParts; i++)
            want.parts[i] = malformed ? '0 : part_value[i];
         want.form = seg_form;
         want.bad = malformed;
         expected_addresses.push_back(want);
         parse_phase = PH_FIRST;
         string_count++;
         seg_count += seg_form;
         bad_count += malformed;
      endfunction

      function void compare_field(string name, logic [PartWidth-1:0] want,
                                  logic [PartWidth-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
         end
      endfunction

      // Called for every accepted response transfer.
      function void check_result(result_type got);
         result_type want;
         if (expected_addresses.size() == 0) begin
            $error("response transfer with no string pending: zone %0d net %0d",
                   $signed(got.parts[IX_ZONE]), $signed(got.parts[IX_NET]));
            fail_count++;
            return;
         end
         want = expected_addresses.pop_front();
         compare_field("zone_out", want.parts[IX_ZONE], got.parts[IX_ZONE]);
         compare_field("net_out", want.parts[IX_NET], got.parts[IX_NET]);
         compare_field("node_out", want.parts[IX_NODE], got.parts[IX_NODE]);
         compare_field("point_out", want.parts[IX_POINT], got.parts[IX_POINT]);
         compare_field("segment_form", PartWidth'(want.form), PartWidth'(got.form));
         compare_field("bad", PartWidth'(want.bad), PartWidth'(got.bad));
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [7:0]                  req_char_in;
   logic                        req_wildcard_ok;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [PartWidth-1:0] rsp_zone_out;
   logic signed [PartWidth-1:0] rsp_net_out;
   logic signed [PartWidth-1:0] rsp_node_out;
   logic signed [PartWidth-1:0] rsp_point_out;
   logic                        rsp_segment_form;
   logic                        rsp_bad;
   logic                        csr_write;
   logic [IdxWidth-1:0]         csr_index;
   logic [NumWidth-1:0]         csr_wdata;

   address_scoreboard addresses = new();

   logic [7:0]      text [$];
   int              bytes_sent = 0;
   int              burst_left = 0;
   int              no_gaps_left = 0;
   int              settings_used = 0;
   bit              gaps_on = 1'b1;
   int              hold_requests = 0;
   int              hold_served = 0;
   int              hold_left = 0;
   int              stall_tick = 0;
   stall_style_type stall_style = STALL_NONE;

   fido_address_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_wildcard_ok  (req_wildcard_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_zone_out     (rsp_zone_out),
      .rsp_net_out      (rsp_net_out),
      .rsp_node_out     (rsp_node_out),
      .rsp_point_out    (rsp_point_out),
      .rsp_segment_form (rsp_segment_form),
      .rsp_bad          (rsp_bad),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.parts[IX_ZONE] = rsp_zone_out;
            got.parts[IX_NET] = rsp_net_out;
            got.parts[IX_NODE] = rsp_node_out;
            got.parts[IX_POINT] = rsp_point_out;
            got.form = rsp_segment_form;
            got.bad = rsp_bad;
            addresses.check_result(got);
         end
         if (req_valid && !req_stall) addresses.note_byte(req_char_in, req_wildcard_ok);
      end
   end

   // A requested hold keeps the response side stalled long enough for the
   // block to back up into the request channel.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else begin
         stall_tick <= stall_tick + 1;
         case (stall_style)
            STALL_RANDOM:   rsp_stall <= $urandom_range(0, 99) < 35;
            STALL_PERIODIC: rsp_stall <= (stall_tick % 7) < 3;
            STALL_HEAVY:    rsp_stall <= $urandom_range(0, 99) < 85;
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic put_byte(input logic [7:0] c, input logic wild);
      req_valid <= 1'b1;
      req_char_in <= c;
      req_wildcard_ok <= wild;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input logic wild, input bit flips);
      logic [7:0] c;
      for (int i = 0; i <= text.size(); i++) begin
         c = (i == text.size()) ? CH_NUL : text[i];
         if (gaps_on) begin
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
         end
         put_byte(c, flips ? ($urandom_range(0, 1) == 1) : wild);
      end
   endtask

   task automatic send_literal(input string s, input logic wild);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_text(wild, 1'b0);
   endtask

   // The extra edge lets the monitor take in a transfer from the last edge.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (addresses.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [NumWidth-1:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      addresses.set_default(idx, v);
   endtask

   task automatic write_defaults(input logic [NumWidth-1:0] z, n, d);
      settle();
      write_reg(CSR_DEFAULT_ZONE, z);
      write_reg(CSR_DEFAULT_NET, n);
      write_reg(CSR_DEFAULT_NODE, d);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] special_byte();
      case ($urandom_range(0, 8))
         0: return CH_COLON;
         1: return CH_SLASH;
         2: return CH_DOT;
         3: return CH_AT;
         4: return CH_STAR;
         5: return CH_LO_P;
         6: return CH_UP_F;
         7: return CH_LO_N;
         default: return CH_UP_Z;
      endcase
   endfunction

   function automatic void push_digits();
      int n;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void push_colon_num();
      if ($urandom_range(0, 7) == 0) text.push_back(CH_STAR);
      else push_digits();
   endfunction

   function automatic void push_junk(input int most, input bit dots_ok);
      logic [7:0] c;
      repeat ($urandom_range(1, most)) begin
         c = any_byte();
         while (!dots_ok && c == CH_DOT) c = any_byte();
         text.push_back(c);
      end
   endfunction

   function automatic void build_colon();
      bit has_zone;
      int shape;
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
         has_zone = 1'($urandom_range(0, 1));
         if (has_zone) begin
            push_colon_num();
            text.push_back(CH_COLON);
         end
         if (has_zone ? $urandom_range(0, 9) != 0 : $urandom_range(0, 2) != 0) begin
            push_colon_num();
            text.push_back(CH_SLASH);
         end
         push_colon_num();
         if ($urandom_range(0, 1)) begin
            text.push_back(CH_DOT);
            push_colon_num();
         end
      end else if (shape < 8) begin
         text.push_back(CH_SLASH);
         push_colon_num();
         if ($urandom_range(0, 3) == 0) begin
            text.push_back(CH_SLASH);
            push_digits();
         end else if ($urandom_range(0, 1)) begin
            text.push_back(CH_DOT);
            push_colon_num();
         end
      end else begin
         text.push_back(CH_DOT);
         push_colon_num();
         if ($urandom_range(0, 3) == 0) begin
            text.push_back(CH_DOT);
            push_digits();
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         text.push_back(CH_AT);
         push_junk(8, 1'b1);
      end
   endfunction

   function automatic void push_seg(input logic [7:0] lower, input logic [7:0] upper);
      if (text.size() != 0) text.push_back(CH_DOT);
      text.push_back($urandom_range(0, 1) ? lower : upper);
      push_digits();
      if ($urandom_range(0, 5) == 0) push_junk(4, 1'b0);
   endfunction

   function automatic void build_segment();
      int count;
      int point_at;
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
      point_at = $urandom_range(0, 1) ? $urandom_range(0, count) : -1;
      for (int i = 0; i <= count; i++) begin
         if (i == point_at) push_seg(CH_LO_P, CH_UP_P);
         if (i < count) begin
            case (i)
               0: push_seg(CH_LO_F, CH_UP_F);
               1: push_seg(CH_LO_N, CH_UP_N);
               default: push_seg(CH_LO_Z, CH_UP_Z);
            endcase
         end
      end
      if (count == 3 && $urandom_range(0, 2) == 0) begin
         text.push_back(CH_DOT);
         push_junk(8, 1'b1);
      end
   endfunction

   function automatic void mutate();
      int pos;
      repeat ($urandom_range(1, 2)) begin
         pos = $urandom_range(0, text.size());
         case ($urandom_range(0, 3))
            0: if (pos < text.size()) text[pos] = any_byte();
            1: if (pos < text.size()) text.delete(pos);
            2: text.insert(pos, any_byte());
            default: text.insert(pos, special_byte());
         endcase
      end
   endfunction

   task automatic run_random(input int count);
      int target;
      int pick;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 5) == 0)
            stall_style = stall_style_type'($urandom_range(0, 3));
         if (no_gaps_left > 0) begin
            gaps_on = 1'b0;
            no_gaps_left--;
         end else begin
            gaps_on = $urandom_range(0, 4) != 0;
         end
         text.delete();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            build_colon();
         end else if (pick < 80) begin
            build_segment();
         end else if (pick < 95) begin
            if (pick < 88) build_colon();
            else build_segment();
            mutate();
         end else if ($urandom_range(0, 3) != 0) begin
            push_junk(8, 1'b1);
         end
         send_text($urandom_range(0, 4) != 0, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_in = CH_NUL;
      req_wildcard_ok = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_DEFAULT_ZONE;
      csr_wdata = NUM_MIN;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_defaults(NUM_MIN, NUM_MIN, NUM_MIN);
      send_literal("", 1'b0);
      send_literal("2:5/9.1", 1'b0);
      send_literal("f3.n4.z5", 1'b0);
      send_literal("*", 1'b1);
      send_literal("99999", 1'b0);
      run_random(PhaseBytes);

      // The sender also stops midway until every response is back.
      write_defaults(NUM_MAX, NUM_MAX, NUM_MAX);
      run_random(PhaseBytes / 2);
      settle();
      run_random(PhaseBytes / 2);

      write_defaults(NumWidth'($urandom_range(0, 32767)), NumWidth'($urandom_range(0, 32767)),
                     NumWidth'($urandom_range(0, 32767)));
      run_random(PhaseBytes);

      // Long receiver hold while the sender keeps offering bytes back to back.
      write_defaults(NUM_MAX, NUM_MIN, NumWidth'($urandom_range(0, 32767)));
      no_gaps_left = 40;
      hold_requests++;
      run_random(PhaseBytes);

      write_defaults(NUM_MIN, NumWidth'($urandom_range(0, 32767)), NUM_MAX);
      run_random(PhaseBytes);

      settle();
      repeat (8) @(posedge clock);
      $display("Parsed %0d address strings (%0d bytes) under %0d sets of defaults.",
               addresses.string_count, bytes_sent, settings_used);
      $display("Of these, %0d were in segment form and %0d were malformed.",
               addresses.seg_count, addresses.bad_count);
      if (addresses.fail_count == 0 && addresses.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
